// ===== hdl/command_message_deframer_core_assert.svh =====
// assertion macros for the deframer rtl, used by the request queue
// needs a clk and an active-low rst_n in the scope of use
`ifndef COMMAND_MESSAGE_DEFRAMER_CORE_ASSERT_SVH
`define COMMAND_MESSAGE_DEFRAMER_CORE_ASSERT_SVH

// condition holds at every edge out of reset
`define CMD_DFR_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the next cycle
`define CMD_DFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/cmd_dfr_pkg.sv =====
// shared types and constants for the command message deframer
// no dependencies
`default_nettype none

package cmd_dfr_pkg;

  // message format
  localparam int SMALL_PAYLOAD_MAX = 8;
  localparam int STORE_SIZE        = 1024;   // power of two
  localparam int LEN_W             = 10;
  localparam int ADDR_W            = 10;
  localparam int SLOT_W            = 3;
  localparam int BYTE_W            = 8;
  localparam int CMD_W             = 7;
  localparam int KIND_W            = 2;

  // request queue between front and back
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // result kinds
  localparam logic [KIND_W-1:0] KIND_HEADER = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ARG    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_STORE  = 2'd2;

  // classified request handed from front to back
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SLOT_W-1:0] slot;
    logic [LEN_W-1:0]  offset;
    logic [BYTE_W-1:0] data;
    logic [CMD_W-1:0]  command;
    logic [LEN_W-1:0]  length;
    logic              done;
  } dfr_req_t;

endpackage

`default_nettype wire

// ===== hdl/cmd_dfr_front.sv =====
// front end: header / payload state machine, classifies each byte
// depends on cmd_dfr_pkg
`default_nettype none

module cmd_dfr_front (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            push,
  input  wire logic [cmd_dfr_pkg::BYTE_W-1:0]  rx_byte,
  output cmd_dfr_pkg::dfr_req_t                req
);

  localparam logic [1:0] PH_HDR1 = 2'd0;
  localparam logic [1:0] PH_HDR2 = 2'd1;
  localparam logic [1:0] PH_DATA = 2'd2;

  logic [1:0]                        phase_r, phase_nxt;
  logic [cmd_dfr_pkg::CMD_W-1:0]     cmd_r, cmd_nxt;
  logic [cmd_dfr_pkg::LEN_W-1:0]     len_r, len_nxt;
  logic [cmd_dfr_pkg::LEN_W-1:0]     cnt_r, cnt_nxt;
  logic [cmd_dfr_pkg::LEN_W-1:0]     cnt_inc;
  logic [cmd_dfr_pkg::LEN_W-1:0]     len_hdr2;

  assign cnt_inc  = cnt_r + 1'b1;
  assign len_hdr2 = {len_r[cmd_dfr_pkg::LEN_W-1:cmd_dfr_pkg::BYTE_W], rx_byte};

  // next state and request classification
  always_comb begin
    phase_nxt   = phase_r;
    cmd_nxt     = cmd_r;
    len_nxt     = len_r;
    cnt_nxt     = cnt_r;
    req         = '0;
    req.kind    = cmd_dfr_pkg::KIND_HEADER;
    unique case (phase_r)
      PH_HDR1: begin
        cmd_nxt   = {1'b1, rx_byte[7:2]};
        len_nxt   = {rx_byte[1:0], {cmd_dfr_pkg::BYTE_W{1'b0}}};
        cnt_nxt   = '0;
        phase_nxt = PH_HDR2;
      end
      PH_HDR2: begin
        len_nxt = len_hdr2;
        cnt_nxt = '0;
        if (len_hdr2 == '0) begin
          req.done  = 1'b1;
          phase_nxt = PH_HDR1;
        end else begin
          phase_nxt = PH_DATA;
        end
      end
      PH_DATA: begin
        req.data   = rx_byte;
        req.offset = cnt_r;
        if (len_r <= cmd_dfr_pkg::LEN_W'(cmd_dfr_pkg::SMALL_PAYLOAD_MAX)) begin
          req.kind = cmd_dfr_pkg::KIND_ARG;
          req.slot = cnt_r[cmd_dfr_pkg::SLOT_W-1:0];
        end else begin
          req.kind = cmd_dfr_pkg::KIND_STORE;
        end
        cnt_nxt = cnt_inc;
        if (cnt_inc >= len_r) begin
          req.done  = 1'b1;
          phase_nxt = PH_HDR1;
          cnt_nxt   = '0;
        end
      end
      default: begin
        phase_nxt = PH_HDR1;
      end
    endcase
    req.command = cmd_nxt;
    req.length  = len_nxt;
  end

  // message state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR1;
      cmd_r   <= 7'h40;
      len_r   <= '0;
      cnt_r   <= '0;
    end else if (push) begin
      phase_r <= phase_nxt;
      cmd_r   <= cmd_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/cmd_dfr_queue.sv =====
// short request queue between front and back ends
// depends on cmd_dfr_pkg and the assertion macro header
`default_nettype none
`include "command_message_deframer_core_assert.svh"

module cmd_dfr_queue (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire cmd_dfr_pkg::dfr_req_t push_req,
  output logic                       full,
  input  wire logic                  pop,
  output logic                       q_valid,
  output cmd_dfr_pkg::dfr_req_t      q_req
);

  localparam logic [cmd_dfr_pkg::QCNT_W-1:0] QCNT_FULL = cmd_dfr_pkg::QCNT_W'(cmd_dfr_pkg::QDEPTH);

  cmd_dfr_pkg::dfr_req_t                mem_r [cmd_dfr_pkg::QDEPTH];
  logic [cmd_dfr_pkg::QPTR_W-1:0]       wr_ptr_r, rd_ptr_r;
  logic [cmd_dfr_pkg::QCNT_W-1:0]       count_r, count_nxt;
  logic                                 do_pop;

  assign full    = (count_r == QCNT_FULL);
  assign q_valid = (count_r != '0);
  assign q_req   = mem_r[rd_ptr_r];
  assign do_pop  = pop && q_valid;

  function automatic logic [cmd_dfr_pkg::QPTR_W-1:0] ptr_inc(
    input logic [cmd_dfr_pkg::QPTR_W-1:0] p
  );
    if (p == cmd_dfr_pkg::QPTR_W'(cmd_dfr_pkg::QDEPTH - 1)) return '0;
    return p + 1'b1;
  endfunction

  // occupancy
  always_comb begin
    count_nxt = count_r;
    if (push && !do_pop) count_nxt = count_r + 1'b1;
    else if (do_pop && !push) count_nxt = count_r - 1'b1;
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_req;
  end

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push)   wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (do_pop) rd_ptr_r <= ptr_inc(rd_ptr_r);
      count_r <= count_nxt;
    end
  end

  // checks
  `CMD_DFR_ASSERT(a_count_bound, count_r <= QCNT_FULL, "queue overfilled")
  `CMD_DFR_ASSERT_NEXT(a_count_up, push && !do_pop, count_r == $past(count_r) + 1'b1, "no rise")
  `CMD_DFR_ASSERT_NEXT(a_count_dn, do_pop && !push, count_r == $past(count_r) - 1'b1, "no fall")
  `CMD_DFR_ASSERT_NEXT(a_ptr_wrap, count_r == '0 && !push, rd_ptr_r == wr_ptr_r, "pointers apart")

endmodule

`default_nettype wire

// ===== hdl/cmd_dfr_back.sv =====
// back end: store address generation and output register
// depends on cmd_dfr_pkg
`default_nettype none

module cmd_dfr_back (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [cmd_dfr_pkg::ADDR_W-1:0]   cfg_wdata,
  input  wire logic                             q_valid,
  input  wire cmd_dfr_pkg::dfr_req_t            q_req,
  output logic                                  pop,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [cmd_dfr_pkg::KIND_W-1:0]        out_kind,
  output logic [cmd_dfr_pkg::SLOT_W-1:0]        out_arg_slot,
  output logic [cmd_dfr_pkg::ADDR_W-1:0]        out_store_address,
  output logic [cmd_dfr_pkg::BYTE_W-1:0]        out_data_byte,
  output logic [cmd_dfr_pkg::CMD_W-1:0]         out_command,
  output logic [cmd_dfr_pkg::LEN_W-1:0]         out_msg_length,
  output logic                                  out_message_done
);

  localparam int SUM_W = cmd_dfr_pkg::ADDR_W + 1;

  logic [cmd_dfr_pkg::ADDR_W-1:0] store_base_r;
  logic                           out_valid_r;
  logic [SUM_W-1:0]               addr_sum;
  logic [SUM_W-1:0]               addr_wrap;
  logic [cmd_dfr_pkg::ADDR_W-1:0] addr_nxt;

  // base plus offset, wrapped to the store size
  assign addr_sum  = SUM_W'(store_base_r) + SUM_W'(q_req.offset);
  assign addr_wrap = addr_sum % SUM_W'(cmd_dfr_pkg::STORE_SIZE);
  assign addr_nxt  = (q_req.kind == cmd_dfr_pkg::KIND_STORE) ?
                     addr_wrap[cmd_dfr_pkg::ADDR_W-1:0] : '0;

  assign pop       = q_valid && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;

  // store base register
  always_ff @(posedge clk) begin
    if (!rst_n) store_base_r <= '0;
    else if (cfg_we) store_base_r <= cfg_wdata;
  end

  // output valid
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (pop) out_valid_r <= 1'b1;
    else if (!out_stall) out_valid_r <= 1'b0;
  end

  // output payload
  always_ff @(posedge clk) begin
    if (pop) begin
      out_kind          <= q_req.kind;
      out_arg_slot      <= q_req.slot;
      out_store_address <= addr_nxt;
      out_data_byte     <= q_req.data;
      out_command       <= q_req.command;
      out_msg_length    <= q_req.length;
      out_message_done  <= q_req.done;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/command_message_deframer_core.sv =====
// command message deframer, one result per received byte
// path: each accepted byte's request is registered in the request queue, then in the output register
// throughput: one byte per cycle while the request queue is not full
// a two-entry request queue lets input and output stall independently
// reset: synchronous active-low rst_n clears message state, queue and store base
// depends on cmd_dfr_pkg, cmd_dfr_front, cmd_dfr_queue, cmd_dfr_back
`default_nettype none

module command_message_deframer_core (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [cmd_dfr_pkg::ADDR_W-1:0]   cfg_wdata,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [cmd_dfr_pkg::BYTE_W-1:0]   in_rx_byte,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [cmd_dfr_pkg::KIND_W-1:0]        out_kind,
  output logic [cmd_dfr_pkg::SLOT_W-1:0]        out_arg_slot,
  output logic [cmd_dfr_pkg::ADDR_W-1:0]        out_store_address,
  output logic [cmd_dfr_pkg::BYTE_W-1:0]        out_data_byte,
  output logic [cmd_dfr_pkg::CMD_W-1:0]         out_command,
  output logic [cmd_dfr_pkg::LEN_W-1:0]         out_msg_length,
  output logic                                  out_message_done
);

  cmd_dfr_pkg::dfr_req_t front_req;
  cmd_dfr_pkg::dfr_req_t q_req;
  logic                  q_full;
  logic                  q_valid;
  logic                  q_pop;
  logic                  push;

  // accept while the queue has room and reset is released
  assign in_stall = q_full || !rst_n;
  assign push     = in_valid && !in_stall;

  cmd_dfr_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .rx_byte (in_rx_byte),
    .req     (front_req)
  );

  cmd_dfr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_req (front_req),
    .full     (q_full),
    .pop      (q_pop),
    .q_valid  (q_valid),
    .q_req    (q_req)
  );

  cmd_dfr_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .q_valid           (q_valid),
    .q_req             (q_req),
    .pop               (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_arg_slot      (out_arg_slot),
    .out_store_address (out_store_address),
    .out_data_byte     (out_data_byte),
    .out_command       (out_command),
    .out_msg_length    (out_msg_length),
    .out_message_done  (out_message_done)
  );

endmodule

`default_nettype wire
